/* design/alr_pkg.sv */
// Shared types, constants and helper functions for the arc-length resampler.
package alr_pkg;

    localparam int COORD_W   = 24;
    localparam int IVL_W     = 23;
    localparam int DIST_W    = 25;
    localparam int KIND_W    = 2;
    localparam int NUM_KINDS = 4;
    localparam int KC_W      = 3;
    localparam int PROD_W    = 50;
    localparam int NUM_W     = 51;
    localparam int DEN_W     = 26;
    localparam int REM_W     = 29;
    localparam int ITERS     = 25;
    localparam int ITER_W    = 5;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_KIND_COUNT = 3'd0;
    localparam reg_idx_t REG_INTERVAL_0 = 3'd1;
    localparam reg_idx_t REG_INTERVAL_1 = 3'd2;
    localparam reg_idx_t REG_INTERVAL_2 = 3'd3;
    localparam reg_idx_t REG_INTERVAL_3 = 3'd4;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_MUL,
        OP_SQRT,
        OP_DIV
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_stat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [KIND_W-1:0]         kind;
    } marker_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_SQX,
        S_SQY,
        S_SQRT,
        S_SQRT_W,
        S_ZCHK,
        S_CHECK,
        S_MULX,
        S_DIVX,
        S_DIVX_W,
        S_MULY,
        S_DIVY,
        S_DIVY_W,
        S_STEP,
        S_FINISH,
        S_DRAIN_RD,
        S_DRAIN_OUT
    } seq_state_t;

    // Next table entry, wrapping at the number of entries in use.
    function automatic logic [KIND_W-1:0] advance_kind(input logic [KIND_W-1:0] k,
                                                       input logic [KC_W-1:0] kc);
        logic [KC_W-1:0] used;
        logic [KC_W-1:0] nxt;
        if (kc == '0)
            used = KC_W'(1);
        else if (kc > KC_W'(NUM_KINDS))
            used = KC_W'(NUM_KINDS);
        else
            used = kc;
        nxt = {1'b0, k} + KC_W'(1);
        return (nxt >= used) ? '0 : nxt[KIND_W-1:0];
    endfunction

endpackage

/* design/alr_if.sv */
// Stream interfaces for input points and emitted markers.
interface alr_point_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [alr_pkg::COORD_W-1:0]   in_x;
    logic signed [alr_pkg::COORD_W-1:0]   in_y;

    modport source (output valid, output in_x, output in_y, input ready);
    modport sink   (input valid, input in_x, input in_y, output ready);
endinterface

interface alr_marker_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [alr_pkg::COORD_W-1:0]   out_x;
    logic signed [alr_pkg::COORD_W-1:0]   out_y;
    logic [alr_pkg::KIND_W-1:0]           kind_index;
    logic                                 last_in_run;
    logic                                 run_overflow;

    modport source (output valid, output out_x, output out_y, output kind_index,
                    output last_in_run, output run_overflow, input ready);
    modport sink   (input valid, input out_x, input out_y, input kind_index,
                    input last_in_run, input run_overflow, output ready);
endinterface

/* design/alr_regs.sv */
// APB configuration registers: kind count and the interval table.
module alr_regs (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 psel,
    input  logic                                                 penable,
    input  logic                                                 pwrite,
    input  logic [alr_pkg::APB_AW-1:0]                           paddr,
    input  logic [alr_pkg::APB_DW-1:0]                           pwdata,
    output logic [alr_pkg::APB_DW-1:0]                           prdata,
    output logic                                                 pready,
    output logic [alr_pkg::KC_W-1:0]                             kind_count,
    output logic [alr_pkg::NUM_KINDS-1:0][alr_pkg::IVL_W-1:0]    ivl
);

    logic [alr_pkg::KC_W-1:0]                          kc_reg;
    logic [alr_pkg::NUM_KINDS-1:0][alr_pkg::IVL_W-1:0] ivl_reg;
    alr_pkg::reg_idx_t                                 idx;
    logic                                              wr;

    assign idx    = paddr[alr_pkg::APB_AW-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kc_reg  <= alr_pkg::KC_W'(1);
            ivl_reg <= '0;
        end
        else if (wr)
        begin
            case (idx)
                alr_pkg::REG_KIND_COUNT: kc_reg     <= pwdata[alr_pkg::KC_W-1:0];
                alr_pkg::REG_INTERVAL_0: ivl_reg[0] <= pwdata[alr_pkg::IVL_W-1:0];
                alr_pkg::REG_INTERVAL_1: ivl_reg[1] <= pwdata[alr_pkg::IVL_W-1:0];
                alr_pkg::REG_INTERVAL_2: ivl_reg[2] <= pwdata[alr_pkg::IVL_W-1:0];
                alr_pkg::REG_INTERVAL_3: ivl_reg[3] <= pwdata[alr_pkg::IVL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            alr_pkg::REG_KIND_COUNT: prdata = alr_pkg::APB_DW'(kc_reg);
            alr_pkg::REG_INTERVAL_0: prdata = alr_pkg::APB_DW'(ivl_reg[0]);
            alr_pkg::REG_INTERVAL_1: prdata = alr_pkg::APB_DW'(ivl_reg[1]);
            alr_pkg::REG_INTERVAL_2: prdata = alr_pkg::APB_DW'(ivl_reg[2]);
            alr_pkg::REG_INTERVAL_3: prdata = alr_pkg::APB_DW'(ivl_reg[3]);
            default:                 prdata = '0;
        endcase
    end

    assign kind_count = kc_reg;
    assign ivl        = ivl_reg;

endmodule

/* design/alr_arith.sv */
// Shared arithmetic unit: registered multiplier and a shift-subtract engine
// that runs either an integer square root or a restoring division.
module alr_arith (
    input  logic                          clk,
    input  logic                          rst_n,
    input  alr_pkg::arith_cmd_t           cmd,
    input  logic [alr_pkg::DIST_W-1:0]    mul_a,
    input  logic [alr_pkg::DIST_W-1:0]    mul_b,
    input  logic [alr_pkg::PROD_W-1:0]    rad,
    input  logic [alr_pkg::NUM_W-1:0]     num,
    input  logic [alr_pkg::DEN_W-1:0]     den,
    output alr_pkg::arith_stat_t          stat,
    output logic [alr_pkg::PROD_W-1:0]    prod,
    output logic [alr_pkg::DIST_W-1:0]    res
);

    alr_pkg::arith_op_t              op_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic [alr_pkg::ITER_W-1:0]      iter_reg;
    logic [alr_pkg::REM_W-1:0]       rem_reg;
    logic [alr_pkg::DIST_W-1:0]      q_reg;
    logic [alr_pkg::NUM_W-1:0]       src_reg;
    logic [alr_pkg::DEN_W-1:0]       den_reg;
    logic [alr_pkg::PROD_W-1:0]      prod_reg;

    logic [alr_pkg::REM_W-1:0]       shifted;
    logic [alr_pkg::REM_W-1:0]       trial;
    logic [alr_pkg::REM_W-1:0]       diff;
    logic                            ge;

    // Square root brings down two radicand bits per step, division one.
    always_comb
    begin
        if (op_reg == alr_pkg::OP_SQRT)
        begin
            shifted = {rem_reg[alr_pkg::REM_W-3:0], src_reg[alr_pkg::NUM_W-1 -: 2]};
            trial   = {2'b00, q_reg, 2'b01};
        end
        else
        begin
            shifted = {rem_reg[alr_pkg::REM_W-2:0], src_reg[alr_pkg::NUM_W-1]};
            trial   = {3'b000, den_reg};
        end
        ge   = (shifted >= trial);
        diff = shifted - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= alr_pkg::OP_NONE;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                op_reg <= cmd.op;
                case (cmd.op)
                    alr_pkg::OP_MUL:
                    begin
                        done_reg <= 1'b1;
                    end
                    alr_pkg::OP_SQRT, alr_pkg::OP_DIV:
                    begin
                        busy_reg <= 1'b1;
                        iter_reg <= alr_pkg::ITER_W'(alr_pkg::ITERS);
                    end
                    default: ;
                endcase
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - alr_pkg::ITER_W'(1);
                if (iter_reg == alr_pkg::ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            case (cmd.op)
                alr_pkg::OP_MUL:
                begin
                    prod_reg <= mul_a * mul_b;
                end
                alr_pkg::OP_SQRT:
                begin
                    rem_reg <= '0;
                    q_reg   <= '0;
                    src_reg <= {rad, 1'b0};
                end
                alr_pkg::OP_DIV:
                begin
                    // The quotient fits in DIST_W bits, so the upper numerator
                    // bits are already below the divisor.
                    rem_reg <= alr_pkg::REM_W'(num[alr_pkg::NUM_W-1:alr_pkg::DIST_W]);
                    q_reg   <= '0;
                    src_reg <= {num[alr_pkg::DIST_W-1:0],
                                {(alr_pkg::NUM_W-alr_pkg::DIST_W){1'b0}}};
                    den_reg <= den;
                end
                default: ;
            endcase
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff : shifted;
            q_reg   <= {q_reg[alr_pkg::DIST_W-2:0], ge};
            if (op_reg == alr_pkg::OP_SQRT)
                src_reg <= {src_reg[alr_pkg::NUM_W-3:0], 2'b00};
            else
                src_reg <= {src_reg[alr_pkg::NUM_W-2:0], 1'b0};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = prod_reg;
    assign res       = q_reg;

endmodule

/* design/alr_buf.sv */
// Marker buffer: holds one point's markers until they are sent out.
module alr_buf #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  alr_pkg::marker_t     wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output alr_pkg::marker_t     rd_data
);

    alr_pkg::marker_t mem [DEPTH];
    alr_pkg::marker_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule

/* design/polyline_arc_length_resampler.sv */
// Top level: sequencer around the shared arithmetic unit and the marker buffer.
// One point at a time; not ready until all markers of that point are delivered.
// First point: its marker is written to the buffer, then read back and offered. Later
// points: a square root for the distance, then two 25-step divisions per marker, then
// each marker beat is read from the buffer and offered until taken. Reset (rst_n low, async)
// clears the run state and sets kind_count to 1 and all intervals to 0.
module polyline_arc_length_resampler #(
    parameter int MAX_RUN = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    alr_point_if.sink                     point,
    alr_marker_if.source                  marker,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [alr_pkg::APB_AW-1:0]    paddr,
    input  logic [alr_pkg::APB_DW-1:0]    pwdata,
    output logic [alr_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int CW = $clog2(MAX_RUN + 1);
    localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    localparam int CW_ = alr_pkg::COORD_W;
    localparam int DW_ = alr_pkg::DIST_W;

    alr_pkg::seq_state_t state_reg, state_next;

    logic [alr_pkg::KC_W-1:0]                          kind_count;
    logic [alr_pkg::NUM_KINDS-1:0][alr_pkg::IVL_W-1:0] ivl;

    logic signed [CW_-1:0]           x_reg, y_reg, prev_x_reg, prev_y_reg;
    logic                            started_reg;
    logic [DW_-1:0]                  carried_reg;
    logic [alr_pkg::KIND_W-1:0]      nk_reg;
    logic [DW_-1:0]                  inc_reg, req_reg, qx_reg, qy_reg;
    logic [alr_pkg::PROD_W-1:0]      acc_reg;
    logic [CW-1:0]                   cnt_reg, rd_idx_reg;
    logic                            over_reg;

    alr_pkg::arith_cmd_t             cmd;
    alr_pkg::arith_stat_t            stat;
    logic [DW_-1:0]                  mul_a, mul_b, res;
    logic [alr_pkg::PROD_W-1:0]      prod, rad;
    logic [alr_pkg::NUM_W-1:0]       num;
    logic [alr_pkg::DEN_W-1:0]       den;

    logic                            wr_en, rd_en;
    alr_pkg::marker_t                wr_data, rd_data;

    logic [DW_-1:0]                  dx, dy, mx, my;
    logic [DW_-1:0]                  iv_cur;
    logic [DW_:0]                    sum_cs;
    logic                            due;
    logic [DW_-1:0]                  req_val;
    logic signed [CW_-1:0]           tx, ty;
    logic                            last_beat;
    logic [alr_pkg::KIND_W-1:0]      nk_adv;

    alr_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .kind_count (kind_count),
        .ivl        (ivl)
    );

    alr_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .rad   (rad),
        .num   (num),
        .den   (den),
        .stat  (stat),
        .prod  (prod),
        .res   (res)
    );

    alr_buf #(
        .DEPTH (MAX_RUN),
        .AW    (AW)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // Segment geometry against the current previous point.
    always_comb
    begin
        dx      = {x_reg[CW_-1], x_reg} - {prev_x_reg[CW_-1], prev_x_reg};
        dy      = {y_reg[CW_-1], y_reg} - {prev_y_reg[CW_-1], prev_y_reg};
        mx      = dx[DW_-1] ? (DW_'(0) - dx) : dx;
        my      = dy[DW_-1] ? (DW_'(0) - dy) : dy;
        iv_cur  = DW_'(ivl[nk_reg]);
        sum_cs  = {1'b0, carried_reg} + {1'b0, inc_reg};
        due     = (sum_cs > {1'b0, iv_cur});
        req_val = (carried_reg >= iv_cur) ? '0 : (iv_cur - carried_reg);
        tx      = dx[DW_-1] ? (prev_x_reg - qx_reg[CW_-1:0]) : (prev_x_reg + qx_reg[CW_-1:0]);
        ty      = dy[DW_-1] ? (prev_y_reg - qy_reg[CW_-1:0]) : (prev_y_reg + qy_reg[CW_-1:0]);
        rad     = acc_reg + prod;
        num     = {prod, 1'b0} + alr_pkg::NUM_W'(inc_reg);
        den     = {inc_reg, 1'b0};
        nk_adv  = alr_pkg::advance_kind(nk_reg, kind_count);
        last_beat = (rd_idx_reg == CW'(cnt_reg - CW'(1)));
    end

    always_comb
    begin
        case (state_reg)
            alr_pkg::S_SQX:
            begin
                mul_a = mx;
                mul_b = mx;
            end
            alr_pkg::S_SQY:
            begin
                mul_a = my;
                mul_b = my;
            end
            alr_pkg::S_MULX:
            begin
                mul_a = mx;
                mul_b = req_reg;
            end
            default:
            begin
                mul_a = my;
                mul_b = req_reg;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            alr_pkg::S_IDLE:
                if (point.valid)
                    state_next = alr_pkg::S_START;
            alr_pkg::S_START:
                state_next = started_reg ? alr_pkg::S_SQX : alr_pkg::S_DRAIN_RD;
            alr_pkg::S_SQX:
                state_next = alr_pkg::S_SQY;
            alr_pkg::S_SQY:
                state_next = alr_pkg::S_SQRT;
            alr_pkg::S_SQRT:
                state_next = alr_pkg::S_SQRT_W;
            alr_pkg::S_SQRT_W:
                if (stat.done)
                    state_next = alr_pkg::S_ZCHK;
            alr_pkg::S_ZCHK:
                state_next = (iv_cur == '0) ? alr_pkg::S_DRAIN_RD : alr_pkg::S_CHECK;
            alr_pkg::S_CHECK:
            begin
                if (!due || cnt_reg == CW'(MAX_RUN))
                    state_next = alr_pkg::S_FINISH;
                else if (inc_reg == '0)
                    state_next = alr_pkg::S_STEP;
                else
                    state_next = alr_pkg::S_MULX;
            end
            alr_pkg::S_MULX:
                state_next = alr_pkg::S_DIVX;
            alr_pkg::S_DIVX:
                state_next = alr_pkg::S_DIVX_W;
            alr_pkg::S_DIVX_W:
                if (stat.done)
                    state_next = alr_pkg::S_MULY;
            alr_pkg::S_MULY:
                state_next = alr_pkg::S_DIVY;
            alr_pkg::S_DIVY:
                state_next = alr_pkg::S_DIVY_W;
            alr_pkg::S_DIVY_W:
                if (stat.done)
                    state_next = alr_pkg::S_STEP;
            alr_pkg::S_STEP:
                state_next = alr_pkg::S_CHECK;
            alr_pkg::S_FINISH:
                state_next = (cnt_reg == '0) ? alr_pkg::S_IDLE : alr_pkg::S_DRAIN_RD;
            alr_pkg::S_DRAIN_RD:
                state_next = alr_pkg::S_DRAIN_OUT;
            alr_pkg::S_DRAIN_OUT:
                if (marker.ready)
                    state_next = last_beat ? alr_pkg::S_IDLE : alr_pkg::S_DRAIN_RD;
            default:
                state_next = alr_pkg::S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        cmd.start = 1'b0;
        cmd.op    = alr_pkg::OP_NONE;
        wr_en     = 1'b0;
        wr_data   = '{x: tx, y: ty, kind: nk_reg};
        rd_en     = 1'b0;
        case (state_reg)
            alr_pkg::S_START:
            begin
                wr_en   = !started_reg;
                wr_data = '{x: x_reg, y: y_reg, kind: '0};
            end
            alr_pkg::S_SQX, alr_pkg::S_SQY, alr_pkg::S_MULX, alr_pkg::S_MULY:
            begin
                cmd.start = 1'b1;
                cmd.op    = alr_pkg::OP_MUL;
            end
            alr_pkg::S_SQRT:
            begin
                cmd.start = 1'b1;
                cmd.op    = alr_pkg::OP_SQRT;
            end
            alr_pkg::S_DIVX, alr_pkg::S_DIVY:
            begin
                cmd.start = 1'b1;
                cmd.op    = alr_pkg::OP_DIV;
            end
            alr_pkg::S_ZCHK:
            begin
                wr_en   = (iv_cur == '0);
                wr_data = '{x: x_reg, y: y_reg, kind: nk_reg};
            end
            alr_pkg::S_STEP:
                wr_en = 1'b1;
            alr_pkg::S_DRAIN_RD:
                rd_en = 1'b1;
            default: ;
        endcase
    end

    assign point.ready         = (state_reg == alr_pkg::S_IDLE);
    assign marker.valid        = (state_reg == alr_pkg::S_DRAIN_OUT);
    assign marker.out_x        = rd_data.x;
    assign marker.out_y        = rd_data.y;
    assign marker.kind_index   = rd_data.kind;
    assign marker.last_in_run  = last_beat;
    assign marker.run_overflow = over_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= alr_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Run state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            carried_reg <= '0;
            nk_reg      <= '0;
            cnt_reg     <= '0;
            rd_idx_reg  <= '0;
            over_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                alr_pkg::S_IDLE:
                    if (point.valid)
                    begin
                        cnt_reg    <= '0;
                        rd_idx_reg <= '0;
                        over_reg   <= 1'b0;
                    end
                alr_pkg::S_START:
                    if (!started_reg)
                    begin
                        started_reg <= 1'b1;
                        prev_x_reg  <= x_reg;
                        prev_y_reg  <= y_reg;
                        carried_reg <= '0;
                        nk_reg      <= alr_pkg::advance_kind('0, kind_count);
                        cnt_reg     <= CW'(1);
                    end
                alr_pkg::S_ZCHK:
                    if (iv_cur == '0)
                    begin
                        prev_x_reg  <= x_reg;
                        prev_y_reg  <= y_reg;
                        carried_reg <= '0;
                        nk_reg      <= nk_adv;
                        cnt_reg     <= CW'(1);
                    end
                alr_pkg::S_CHECK:
                    if (due && cnt_reg == CW'(MAX_RUN))
                        over_reg <= 1'b1;
                alr_pkg::S_STEP:
                begin
                    prev_x_reg  <= tx;
                    prev_y_reg  <= ty;
                    carried_reg <= '0;
                    nk_reg      <= nk_adv;
                    cnt_reg     <= cnt_reg + CW'(1);
                end
                alr_pkg::S_FINISH:
                begin
                    prev_x_reg <= x_reg;
                    prev_y_reg <= y_reg;
                    if (over_reg)
                        carried_reg <= '0;
                    else if (sum_cs[DW_])
                        carried_reg <= '1;
                    else
                        carried_reg <= sum_cs[DW_-1:0];
                end
                alr_pkg::S_DRAIN_OUT:
                    if (marker.ready && !last_beat)
                        rd_idx_reg <= rd_idx_reg + CW'(1);
                default: ;
            endcase
        end
    end

    // Working values of the current point.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            alr_pkg::S_IDLE:
                if (point.valid)
                begin
                    x_reg <= point.in_x;
                    y_reg <= point.in_y;
                end
            alr_pkg::S_SQY:
                acc_reg <= prod;
            alr_pkg::S_SQRT_W:
                if (stat.done)
                    inc_reg <= res;
            alr_pkg::S_CHECK:
            begin
                req_reg <= req_val;
                qx_reg  <= '0;
                qy_reg  <= '0;
            end
            alr_pkg::S_DIVX_W:
                if (stat.done)
                    qx_reg <= res;
            alr_pkg::S_DIVY_W:
                if (stat.done)
                    qy_reg <= res;
            alr_pkg::S_STEP:
                inc_reg <= inc_reg - req_reg;
            default: ;
        endcase
    end

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        point.ready |-> !marker.valid)
        else $error("input taken while markers are pending");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_RUN))
        else $error("marker count beyond run limit");

    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        marker.valid && marker.run_overflow |-> cnt_reg == CW'(MAX_RUN))
        else $error("overflow flagged on a run that is not full");

    a_busy_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> (state_reg == alr_pkg::S_SQRT_W) || (state_reg == alr_pkg::S_DIVX_W)
                      || (state_reg == alr_pkg::S_DIVY_W))
        else $error("arithmetic unit busy outside a wait state");

endmodule
